>>> rtl/core/fbpa_pkg.sv
// Shared package for the fixed block pool allocator.
// Holds field widths, status and opcode codes, parameter defaults and the
// divider status type. Depends on nothing.
`default_nettype none

package fbpa_pkg;

	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 3;

	localparam int DEFAULT_BLOCK_COUNT  = 64;
	localparam int DEFAULT_BLOCK_STRIDE = 64;

	localparam logic OPC_ALLOC = 1'b0;
	localparam logic OPC_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd2;
	localparam logic [STATUS_W-1:0] STS_ALIGN     = 3'd3;
	localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 3'd4;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/fbpa_link_ram.sv
// Link table storage: one link entry per block, synchronous read.
// One write port and one read port, read data registered.
// Depends on nothing.
`default_nettype none

module fbpa_link_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 7
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/fbpa_div.sv
// Stride divider: turns a byte offset into a block index by a reciprocal
// multiply, then checks the index times the stride against the offset.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_div #(
	parameter int IDX_W        = 6,
	parameter int DIV_W        = 13,
	parameter int BLOCK_STRIDE = fbpa_pkg::DEFAULT_BLOCK_STRIDE
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [DIV_W-1:0]         dividend,
	output fbpa_pkg::div_stat_t           stat,
	output logic      [IDX_W-1:0]         quotient
);

	// floor(x * RECIP >> SHIFT) equals floor(x / BLOCK_STRIDE) for every x below 2^DIV_W
	localparam int SHIFT   = DIV_W + $clog2(BLOCK_STRIDE);
	localparam int RECIP_W = DIV_W + 2;
	localparam int PROD_W  = DIV_W + RECIP_W;
	localparam longint RECIP_VAL = ((longint'(1) << SHIFT) + longint'(BLOCK_STRIDE) - 1)
	                               / longint'(BLOCK_STRIDE);
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_VAL);
	localparam logic [DIV_W-1:0]   STRIDE_V = DIV_W'(BLOCK_STRIDE);

	logic              vld_s1;
	logic [IDX_W-1:0]  quo_s1;
	logic [DIV_W-1:0]  dvd_s1;
	logic              done_q;
	logic              rem_zero_q;
	logic [PROD_W-1:0] recip_prod;
	logic [DIV_W-1:0]  back_prod;

	assign recip_prod = PROD_W'(dividend) * PROD_W'(RECIP);
	assign back_prod  = DIV_W'(quo_s1) * STRIDE_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
		end
	end

	// quo_s1: index estimate; rem_zero_q: zero remainder when index * stride hits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_s1 <= IDX_W'(recip_prod >> SHIFT);
			dvd_s1 <= dividend;
		end
		if (vld_s1) begin
			rem_zero_q <= (back_prod == dvd_s1);
		end
	end

	assign stat.done     = done_q;
	assign stat.rem_zero = rem_zero_q;
	assign quotient      = quo_s1;

endmodule

`default_nettype wire

>>> rtl/core/fixed_block_pool_allocator.sv
// Fixed block pool allocator: top level with request sequencer and link table.
// Depends on fbpa_pkg, fbpa_link_ram and fbpa_div.
//   Requests arrive on in_valid/in_ready with opcode and block_address;
//   one result per request leaves on out_valid/out_ready with status and
//   granted_address. The user writes pool_base through cfg_wr_en/cfg_wr_data
//   while the block is idle; the block does not enforce it or touch the free list.
//   One request is in work at a time. States from transfer in to out_valid:
//     allocate: ALLOC_RD, RESULT; RESULT alone when the pool is empty
//     free: FREE_CHK, RESULT when out of range; FREE_CHK, FREE_DIV, RESULT
//     when misaligned; FREE_CHK, FREE_DIV, FREE_RD, RESULT otherwise
//   The index comes from a reciprocal multiply and a check product in
//   fbpa_div, then a registered link table read; in_ready rises with out_valid.
//   The result sits in an output register: the next request transfers in
//   while a finished result still waits; the sequencer only holds in its
//   result state when that register is still full and out_ready is low.
//   Reset empties the output register, sets the head to block 0 and the
//   fill count to 0; every link entry at or above the fill count reads as
//   its reset value (next index), so no clearing pass is needed.
`default_nettype none

module fixed_block_pool_allocator #(
	parameter int BLOCK_COUNT  = fbpa_pkg::DEFAULT_BLOCK_COUNT,
	parameter int BLOCK_STRIDE = fbpa_pkg::DEFAULT_BLOCK_STRIDE
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [fbpa_pkg::ADDR_W-1:0]   cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          opcode,
	input  wire logic [fbpa_pkg::ADDR_W-1:0]   block_address,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [fbpa_pkg::STATUS_W-1:0] status,
	output logic      [fbpa_pkg::ADDR_W-1:0]   granted_address
);

	localparam int AW       = fbpa_pkg::ADDR_W;
	localparam int SW       = fbpa_pkg::STATUS_W;
	localparam int IDX_W    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int LINK_W   = $clog2(BLOCK_COUNT + 2);
	localparam int FILL_W   = $clog2(BLOCK_COUNT + 1);
	localparam int STRIDE_W = $clog2(BLOCK_STRIDE + 1);
	localparam int DIV_W    = IDX_W + STRIDE_W;
	localparam int PROD_W   = IDX_W + STRIDE_W;

	localparam logic [LINK_W-1:0] LINK_END   = LINK_W'(BLOCK_COUNT);
	localparam logic [LINK_W-1:0] LINK_ALLOC = LINK_W'(BLOCK_COUNT + 1);
	localparam logic [AW-1:0]     LAST_OFF   = AW'((BLOCK_COUNT - 1) * BLOCK_STRIDE);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_ALLOC_RD = 3'd1;
	localparam logic [2:0] S_FREE_CHK = 3'd2;
	localparam logic [2:0] S_FREE_DIV = 3'd3;
	localparam logic [2:0] S_FREE_RD  = 3'd4;
	localparam logic [2:0] S_RESULT   = 3'd5;

	// control state
	logic [2:0]        state_q;
	logic [LINK_W-1:0] head_q;
	logic [FILL_W-1:0] fill_q;
	logic [AW-1:0]     base_q;
	logic              out_valid_q;

	// request payload and pending result
	logic [AW-1:0]     off_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SW-1:0]     res_status_q;
	logic              grant_ok_q;
	logic [PROD_W-1:0] prod_q;

	// memory and divider hookup
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [LINK_W-1:0] mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic [LINK_W-1:0] mem_rdata;
	logic              div_start;
	fbpa_pkg::div_stat_t div_stat;
	logic [IDX_W-1:0]  div_quo;

	logic [IDX_W-1:0]  head_idx;
	logic [IDX_W-1:0]  look_idx;
	logic [LINK_W-1:0] link_val;
	logic              in_xfer;
	logic              range_bad;
	logic              out_free;
	logic              pool_empty;

	assign head_idx   = head_q[IDX_W-1:0];
	assign pool_empty = (head_q == LINK_END);
	assign in_ready   = (state_q == S_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign range_bad  = (off_q > LAST_OFF);
	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;

	// entries at or above the fill count were never written: they read as next index
	assign look_idx = (state_q == S_ALLOC_RD) ? head_idx : idx_q;
	assign link_val = (LINK_W'(look_idx) < LINK_W'(fill_q)) ? mem_rdata
	                                                         : LINK_W'(look_idx) + 1'b1;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = head_idx;
		mem_wdata = LINK_ALLOC;
		mem_re    = 1'b0;
		mem_raddr = head_idx;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				mem_re = in_xfer && (opcode == fbpa_pkg::OPC_ALLOC) && !pool_empty;
			end
			S_ALLOC_RD: begin
				mem_we = 1'b1;
			end
			S_FREE_CHK: begin
				div_start = !range_bad;
			end
			S_FREE_DIV: begin
				mem_re    = div_stat.done && div_stat.rem_zero;
				mem_raddr = div_quo;
			end
			S_FREE_RD: begin
				mem_we    = (link_val == LINK_ALLOC);
				mem_waddr = idx_q;
				mem_wdata = head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			// drop the result once it transfers out; the result state reloads it itself
			if (out_valid_q && out_ready && (state_q != S_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (opcode == fbpa_pkg::OPC_FREE) begin
							state_q <= S_FREE_CHK;
						end else if (pool_empty) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_ALLOC_RD;
						end
					end
				end
				S_ALLOC_RD: begin
					// pop the head and advance the fill count past a fresh entry
					head_q <= link_val;
					if (head_q == LINK_W'(fill_q)) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= S_RESULT;
				end
				S_FREE_CHK: begin
					state_q <= range_bad ? S_RESULT : S_FREE_DIV;
				end
				S_FREE_DIV: begin
					if (div_stat.done) begin
						state_q <= div_stat.rem_zero ? S_FREE_RD : S_RESULT;
					end
				end
				S_FREE_RD: begin
					// push the block back in front of the list
					if (link_val == LINK_ALLOC) begin
						head_q <= LINK_W'(idx_q);
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				off_q        <= block_address - base_q;
				res_status_q <= fbpa_pkg::STS_EMPTY;
				grant_ok_q   <= 1'b0;
			end
			S_ALLOC_RD: begin
				prod_q       <= PROD_W'(head_idx) * PROD_W'(BLOCK_STRIDE);
				res_status_q <= fbpa_pkg::STS_OK;
				grant_ok_q   <= 1'b1;
			end
			S_FREE_CHK: begin
				res_status_q <= fbpa_pkg::STS_RANGE;
			end
			S_FREE_DIV: begin
				idx_q        <= div_quo;
				res_status_q <= fbpa_pkg::STS_ALIGN;
			end
			S_FREE_RD: begin
				res_status_q <= (link_val == LINK_ALLOC) ? fbpa_pkg::STS_OK
				                                         : fbpa_pkg::STS_NOT_ALLOC;
			end
			S_RESULT: begin
				if (out_free) begin
					status          <= res_status_q;
					granted_address <= grant_ok_q ? base_q + AW'(prod_q) : '0;
				end
			end
			default: begin
			end
		endcase
	end

	fbpa_link_ram #(
		.DEPTH  (BLOCK_COUNT),
		.ADDR_W (IDX_W),
		.DATA_W (LINK_W)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fbpa_div #(
		.IDX_W        (IDX_W),
		.DIV_W        (DIV_W),
		.BLOCK_STRIDE (BLOCK_STRIDE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIV_W'(off_q)),
		.stat     (div_stat),
		.quotient (div_quo)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_fixed_block_pool_allocator.sv
// Self-checking testbench for fixed_block_pool_allocator: a stimulus table, then
// random allocate/free traffic over several pool bases and backpressure patterns.
// Depends on fbpa_pkg and the allocator RTL only.

module tb_fixed_block_pool_allocator;

	import fbpa_pkg::*;

	// Geometry of the instance under test (package defaults).
	localparam int NBLK   = DEFAULT_BLOCK_COUNT;
	localparam int STRIDE = DEFAULT_BLOCK_STRIDE;
	localparam int LINK_W = $clog2(NBLK + 2);

	// Link codes: next-free index, end of list, or block handed out.
	localparam logic [LINK_W-1:0] LINK_END   = LINK_W'(NBLK);
	localparam logic [LINK_W-1:0] LINK_TAKEN = LINK_W'(NBLK + 1);
	localparam logic [ADDR_W-1:0] LAST_OFFSET = ADDR_W'((NBLK - 1) * STRIDE);

	// Settle well past the time a free takes to answer.
	localparam int SETTLE_CYCLES   = $clog2(NBLK) + 8;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 215;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   grant;
	} pool_result_t;

	// One directed request; typed_exp marks rows whose answer is written out here.
	typedef struct {
		logic                op;
		logic [ADDR_W-1:0]   addr;
		logic                typed_exp;
		logic [STATUS_W-1:0] exp_status;
		logic [ADDR_W-1:0]   exp_grant;
	} probe_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [ADDR_W-1:0]   cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                opcode = OPC_ALLOC;
	logic [ADDR_W-1:0]   block_address = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   granted_address;

	// Mirror of the allocator: free-list head, link per block and pool base.
	logic [LINK_W-1:0] free_head;
	logic [LINK_W-1:0] links [NBLK];
	logic [ADDR_W-1:0] pool_base;

	pool_result_t answers_due [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic stall_req = 1'b0;
	int mismatches = 0;
	int quiet_cycles = 0;

	// Directed requests after reset (pool base 0, list 0..NBLK-1).
	probe_t probes [] = '{
		'{OPC_FREE,  32'h0000_0000, 1'b1, STS_NOT_ALLOC, 32'h0000_0000},
		'{OPC_ALLOC, 32'hFFFF_FFFF, 1'b1, STS_OK,        32'h0000_0000},
		'{OPC_ALLOC, 32'h0000_0000, 1'b1, STS_OK,        32'h0000_0040},
		'{OPC_ALLOC, 32'hA5A5_A5A5, 1'b0, STS_OK,        32'h0000_0000},
		'{OPC_FREE,  32'hFFFF_FFFF, 1'b1, STS_RANGE,     32'h0000_0000},
		'{OPC_FREE,  32'h0000_0FC0, 1'b1, STS_NOT_ALLOC, 32'h0000_0000},
		'{OPC_FREE,  32'h0000_0FC1, 1'b1, STS_RANGE,     32'h0000_0000},
		'{OPC_FREE,  32'h0000_1000, 1'b1, STS_RANGE,     32'h0000_0000},
		'{OPC_FREE,  32'h0000_0001, 1'b1, STS_ALIGN,     32'h0000_0000},
		'{OPC_FREE,  32'h0000_003F, 1'b1, STS_ALIGN,     32'h0000_0000},
		'{OPC_FREE,  32'h0000_0040, 1'b1, STS_OK,        32'h0000_0000},
		'{OPC_FREE,  32'h0000_0040, 1'b1, STS_NOT_ALLOC, 32'h0000_0000},
		'{OPC_ALLOC, 32'h5A5A_5A5A, 1'b1, STS_OK,        32'h0000_0040},
		'{OPC_FREE,  32'h0000_0000, 1'b1, STS_OK,        32'h0000_0000},
		'{OPC_FREE,  32'h0000_0080, 1'b0, STS_OK,        32'h0000_0000},
		'{OPC_FREE,  32'h0000_0040, 1'b0, STS_OK,        32'h0000_0000},
		'{OPC_ALLOC, 32'h0000_0000, 1'b0, STS_OK,        32'h0000_0000},
		'{OPC_ALLOC, 32'h0000_0000, 1'b0, STS_OK,        32'h0000_0000},
		'{OPC_ALLOC, 32'h0000_0000, 1'b0, STS_OK,        32'h0000_0000},
		'{OPC_FREE,  32'h8000_0000, 1'b1, STS_RANGE,     32'h0000_0000},
		'{OPC_FREE,  32'h7FFF_FFFF, 1'b1, STS_RANGE,     32'h0000_0000}
	};

	fixed_block_pool_allocator i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.block_address   (block_address),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.granted_address (granted_address)
	);

	always #1 clk = ~clk;

	// Rebuild the free list as reset leaves it: 0 -> 1 -> ... -> NBLK-1 -> end.
	function automatic void pool_clear();
		int b;
		free_head = '0;
		pool_base = '0;
		for (b = 0; b < NBLK; b++) begin
			links[b] = LINK_W'(b + 1);
		end
	endfunction

	// Apply one request to the mirror and return the answer the block owes.
	function automatic pool_result_t pool_answer(input logic op, input logic [ADDR_W-1:0] addr);
		pool_result_t res;
		logic [ADDR_W-1:0] offset;
		int slot;
		res.status = STS_OK;
		res.grant = '0;
		if (op == OPC_ALLOC) begin
			if (free_head >= LINK_END) begin
				res.status = STS_EMPTY;
			end else begin
				res.grant = pool_base + ADDR_W'(free_head) * ADDR_W'(STRIDE);
				slot = int'(free_head);
				free_head = links[slot];
				links[slot] = LINK_TAKEN;
			end
		end else begin
			// Offset wraps modulo 2^32, matching the wrapped grant addresses.
			offset = addr - pool_base;
			if (offset > LAST_OFFSET) begin
				res.status = STS_RANGE;
			end else if (offset % ADDR_W'(STRIDE) != '0) begin
				res.status = STS_ALIGN;
			end else begin
				slot = int'(offset / ADDR_W'(STRIDE));
				if (links[slot] != LINK_TAKEN) begin
					res.status = STS_NOT_ALLOC;
				end else begin
					links[slot] = free_head;
					free_head = LINK_W'(slot);
				end
			end
		end
		return res;
	endfunction

	// Offer one request from a falling edge: idle at random, then hold valid and
	// payload until the transfer, and log what the block must answer.
	task automatic offer(input logic op, input logic [ADDR_W-1:0] addr,
			input logic typed_exp, input pool_result_t typed_res);
		pool_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		block_address = addr;
		do @(posedge clk); while (!in_ready);
		res = pool_answer(op, addr);
		answers_due.push_back(typed_exp ? typed_res : res);
		@(negedge clk);
	endtask

	// Draw a random request. Frees are mostly of blocks that are out, the rest
	// are stray or double frees, misaligned, just-out-of-range or wild addresses.
	task automatic pick_request(input int alloc_pct, output logic op,
			output logic [ADDR_W-1:0] addr);
		int taken [$];
		int b;
		int roll;
		addr = $urandom;
		op = OPC_ALLOC;
		if ($urandom_range(99) < alloc_pct) return;
		op = OPC_FREE;
		for (b = 0; b < NBLK; b++) begin
			if (links[b] == LINK_TAKEN) taken.push_back(b);
		end
		roll = $urandom_range(99);
		if (roll < 70 && taken.size() > 0) begin
			b = taken[$urandom_range(taken.size() - 1)];
			addr = pool_base + ADDR_W'(b) * ADDR_W'(STRIDE);
		end else if (roll < 78) begin
			addr = pool_base + ADDR_W'($urandom_range(NBLK - 1)) * ADDR_W'(STRIDE);
		end else if (roll < 86) begin
			addr = pool_base + ADDR_W'($urandom_range(NBLK - 2)) * ADDR_W'(STRIDE)
				+ ADDR_W'($urandom_range(STRIDE - 1, 1));
		end else if (roll < 89) begin
			addr = pool_base + ADDR_W'(NBLK * STRIDE) + ADDR_W'($urandom_range(255));
		end else if (roll < 92) begin
			addr = pool_base - ADDR_W'(1) - ADDR_W'($urandom_range(255));
		end
	endtask

	// Hold until every owed answer is back, then give the block time to settle.
	task automatic drain();
		while (answers_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the pool base while idle; the list itself stays as it is.
	task automatic write_base(input logic [ADDR_W-1:0] value);
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		pool_base = value;
	endtask

	// Result side: drive ready at the falling edge; a stall request turns into
	// one long hold-off so the block fills up and stops taking requests.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_left = HOLD_OFF_CYCLES;
				stall_req = 1'b0;
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Check every result transfer against the oldest owed answer and watch for
	// a hang: too many cycles without any transfer on either side.
	always @(posedge clk) begin
		pool_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected result: status %0d grant %08h", status,
						granted_address);
				mismatches++;
			end else begin
				want = answers_due.pop_front();
				if (status !== want.status || granted_address !== want.grant) begin
					if (mismatches < MAX_REPORTS)
						$display("mismatch: expected status %0d grant %08h, got status %0d grant %08h",
							want.status, want.grant, status, granted_address);
					mismatches++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("tb_fixed_block_pool_allocator failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [ADDR_W-1:0] bases [PHASES];
		int alloc_bias [PHASES];
		logic op;
		logic [ADDR_W-1:0] addr;
		int ph;
		int r;
		int n;

		// Bases: wrap past 2^32, all ones, random, zero, random aligned, mid.
		bases = '{32'hFFFF_F800, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFC0};
		bases[2] = $urandom;
		bases[4] = $urandom & ~ADDR_W'(STRIDE - 1);
		// Alloc-heavy phases run the pool dry, free-heavy ones refill it.
		alloc_bias = '{90, 50, 15, 85, 50, 30};

		pool_clear();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table, back to back, reset base.
		for (r = 0; r < probes.size(); r++) begin
			offer(probes[r].op, probes[r].addr, probes[r].typed_exp,
				'{probes[r].exp_status, probes[r].exp_grant});
		end

		for (ph = 0; ph < PHASES; ph++) begin
			in_valid = 1'b0;
			drain();
			write_base(bases[ph]);
			// Receiver idles more first, then the sender, then neither.
			if (ph < 2) begin
				send_idle_pct = 32;
				recv_idle_pct = 61;
			end else if (ph < 4) begin
				send_idle_pct = 61;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 4) stall_req = 1'b1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick_request(alloc_bias[ph], op, addr);
				offer(op, addr, 1'b0, '0);
			end
		end

		in_valid = 1'b0;
		drain();
		if (mismatches == 0) begin
			$display("tb_fixed_block_pool_allocator passed");
		end else begin
			$display("tb_fixed_block_pool_allocator failed");
		end
		$finish;
	end

endmodule
